[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsm assertion failed");

// next-cycle implication
`define TSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsm assertion failed");

`endif

[rtl/tsm_pkg.sv]
package tsm_pkg;

	// coordinate and result formats
	localparam int COORD_W = 24;
	localparam int FRAC    = 16;
	localparam int OUT_W   = 32;
	localparam int THR_W   = 32;

	// edge component, product and wide value widths
	localparam int EW  = COORD_W + 1;
	localparam int PW  = 2 * EW;
	localparam int CRW = PW + 1;
	localparam int WW  = 2 * PW;
	localparam int DW  = WW + 2;
	localparam int QW  = 2 * OUT_W;
	localparam int SH  = QW + 2 - 2 * FRAC;
	localparam int NW  = WW + 2 * FRAC;
	localparam int R0W = NW - QW;

	// threshold square
	localparam int TW     = THR_W + FRAC;
	localparam int HL     = (TW + 1) / 2;
	localparam int HH     = TW - HL;
	localparam int TSQ_W  = 2 * TW;
	localparam int CMP_W  = (WW > TSQ_W) ? WW : TSQ_W;

	// square root remainder
	localparam int RMW = OUT_W + 2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	typedef logic [8:0][COORD_W-1:0] tsm_coords_t;

	typedef struct packed {
		logic valid;
		logic deg;
		logic sat;
	} tsm_ctl_t;

	typedef struct packed {
		logic [OUT_W-1:0] ratio;
		logic             deg;
	} tsm_res_t;

endpackage

[rtl/tsm_if.sv]
// triangle request channel
interface tsm_item_if;
	logic valid;
	logic ready;
	logic signed [tsm_pkg::COORD_W-1:0] p0_x, p0_y, p0_z;
	logic signed [tsm_pkg::COORD_W-1:0] p1_x, p1_y, p1_z;
	logic signed [tsm_pkg::COORD_W-1:0] p2_x, p2_y, p2_z;

	modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, input ready);
	modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		p2_x, p2_y, p2_z, output ready);
endinterface

// result channel
interface tsm_result_if;
	logic valid;
	logic ready;
	logic [tsm_pkg::OUT_W-1:0] shape_ratio;
	logic degenerate;

	modport source (output valid, shape_ratio, degenerate, input ready);
	modport sink (input valid, shape_ratio, degenerate, output ready);
endinterface

// threshold write channel
interface tsm_cfg_if;
	logic valid;
	logic ready;
	logic [tsm_pkg::THR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/tsm_front.sv]
// Geometry front end: edges, squared lengths, cross product, wide products,
// degenerate and overflow tests. Eight stages, all advancing on adv.
module tsm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            item_valid,
	input  tsm_pkg::tsm_coords_t            coords,
	input  logic [tsm_pkg::TSQ_W-1:0]       tw,
	output tsm_pkg::tsm_ctl_t               ctl,
	output logic [tsm_pkg::DW-1:0]          den,
	output logic [tsm_pkg::DW-1:0]          rem,
	output logic [tsm_pkg::QW-1:0]          low
);
	localparam int EW  = tsm_pkg::EW;
	localparam int PW  = tsm_pkg::PW;
	localparam int CRW = tsm_pkg::CRW;
	localparam int WW  = tsm_pkg::WW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// s1: edge vectors e1 = p1-p0, e2 = p2-p0, e3 = p1-p2
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [EW-1:0] e3_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				e1_s1[a] <= EW'($signed(coords[3+a])) - EW'($signed(coords[a]));
				e2_s1[a] <= EW'($signed(coords[6+a])) - EW'($signed(coords[a]));
				e3_s1[a] <= EW'($signed(coords[3+a])) - EW'($signed(coords[6+a]));
			end
		end
	end

	// s2: component squares and cross product terms
	logic        [PW-1:0] sq_s2 [9];
	logic signed [PW-1:0] m_s2  [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				sq_s2[a]   <= PW'(e1_s1[a] * e1_s1[a]);
				sq_s2[3+a] <= PW'(e2_s1[a] * e2_s1[a]);
				sq_s2[6+a] <= PW'(e3_s1[a] * e3_s1[a]);
			end
			m_s2[0] <= PW'(e1_s1[1] * e2_s1[2]);
			m_s2[1] <= PW'(e1_s1[2] * e2_s1[1]);
			m_s2[2] <= PW'(e1_s1[2] * e2_s1[0]);
			m_s2[3] <= PW'(e1_s1[0] * e2_s1[2]);
			m_s2[4] <= PW'(e1_s1[0] * e2_s1[1]);
			m_s2[5] <= PW'(e1_s1[1] * e2_s1[0]);
		end
	end

	// s3: squared edge lengths and cross product components
	logic        [PW-1:0]  sl_s3 [3];
	logic signed [CRW-1:0] cr_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sl_s3[k] <= sq_s2[3*k] + sq_s2[3*k+1] + sq_s2[3*k+2];
				cr_s3[k] <= CRW'(m_s2[2*k]) - CRW'(m_s2[2*k+1]);
			end
		end
	end

	// s4: magnitudes and the two longer squared edges
	logic [PW-1:0] opa_s4, opb_s4;
	logic [PW-1:0] ab_s4 [3];
	logic          le12, le13, le23;

	assign le12 = sl_s3[0] <= sl_s3[1];
	assign le13 = sl_s3[0] <= sl_s3[2];
	assign le23 = sl_s3[1] <= sl_s3[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++)
				ab_s4[k] <= PW'(cr_s3[k][CRW-1] ? -cr_s3[k] : cr_s3[k]);
			priority if (le12 && le13) begin
				opa_s4 <= sl_s3[1];
				opb_s4 <= sl_s3[2];
			end else if (le23) begin
				opa_s4 <= sl_s3[0];
				opb_s4 <= sl_s3[2];
			end else begin
				opa_s4 <= sl_s3[0];
				opb_s4 <= sl_s3[1];
			end
		end
	end

	// s5: half-width partial products of the four wide products
	logic [PW-1:0] xa [4];
	logic [PW-1:0] xb [4];
	logic [PW-1:0] hh_s5 [4];
	logic [PW-1:0] hl_s5 [4];
	logic [PW-1:0] lh_s5 [4];
	logic [PW-1:0] ll_s5 [4];

	always_comb begin
		xa[0] = opa_s4;
		xb[0] = opb_s4;
		for (int k = 0; k < 3; k++) begin
			xa[k+1] = ab_s4[k];
			xb[k+1] = ab_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				hh_s5[k] <= PW'(xa[k][PW-1:EW] * xb[k][PW-1:EW]);
				hl_s5[k] <= PW'(xa[k][PW-1:EW] * xb[k][EW-1:0]);
				lh_s5[k] <= PW'(xa[k][EW-1:0]  * xb[k][PW-1:EW]);
				ll_s5[k] <= PW'(xa[k][EW-1:0]  * xb[k][EW-1:0]);
			end
		end
	end

	// s6: assemble full products
	logic [WW-1:0] full_s6 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++)
				full_s6[k] <= (WW'(hh_s5[k]) << PW) + (WW'(hl_s5[k]) << EW)
					+ (WW'(lh_s5[k]) << EW) + WW'(ll_s5[k]);
		end
	end

	// s7: squared cross product magnitude
	logic [WW-1:0] prod_s7, csq_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s7 <= full_s6[0];
			csq_s7  <= full_s6[1] + full_s6[2] + full_s6[3];
		end
	end

	// s8: degenerate test, overflow test, divider operands
	logic [tsm_pkg::NW-1:0] num;
	logic                   deg, sat;
	logic [tsm_pkg::DW-1:0] den_s8, rem_s8;
	logic [tsm_pkg::QW-1:0] low_s8;
	logic                   deg_s8, sat_s8;

	assign num = {prod_s7, {(2*tsm_pkg::FRAC){1'b0}}};
	assign deg = tsm_pkg::CMP_W'(csq_s7) < tsm_pkg::CMP_W'(tw);
	assign sat = WW'(prod_s7[WW-1:tsm_pkg::SH]) >= csq_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s8 <= {csq_s7, 2'b00};
			rem_s8 <= tsm_pkg::DW'(num[tsm_pkg::NW-1:tsm_pkg::QW]);
			low_s8 <= num[tsm_pkg::QW-1:0];
			deg_s8 <= deg;
			sat_s8 <= sat;
		end
	end

	assign den = den_s8;
	assign rem = rem_s8;
	assign low = low_s8;
	assign ctl = {v_s8, deg_s8, sat_s8};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

endmodule

[rtl/tsm_div.sv]
// Restoring divider, one quotient bit per stage: floor(num / den) for a
// quotient known to fit in QW bits.
module tsm_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  tsm_pkg::tsm_ctl_t        ctl,
	input  logic [tsm_pkg::DW-1:0]   den,
	input  logic [tsm_pkg::DW-1:0]   rem,
	input  logic [tsm_pkg::QW-1:0]   low,
	output tsm_pkg::tsm_ctl_t        quo_ctl,
	output logic [tsm_pkg::QW-1:0]   quo
);
	localparam int DW = tsm_pkg::DW;
	localparam int QW = tsm_pkg::QW;

	tsm_pkg::tsm_ctl_t ctl_sd [QW];
	logic [DW-1:0]     den_sd [QW];
	logic [DW-1:0]     rem_sd [QW];
	logic [QW-1:0]     low_sd [QW];
	logic [QW-1:0]     quo_sd [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		tsm_pkg::tsm_ctl_t cur_ctl;
		logic [DW-1:0]     cur_den, cur_rem;
		logic [QW-1:0]     cur_low, cur_quo;
		logic [DW:0]       trial, diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_ctl = ctl;
			assign cur_den = den;
			assign cur_rem = rem;
			assign cur_low = low;
			assign cur_quo = '0;
		end else begin : g_next
			assign cur_ctl = ctl_sd[k-1];
			assign cur_den = den_sd[k-1];
			assign cur_rem = rem_sd[k-1];
			assign cur_low = low_sd[k-1];
			assign cur_quo = quo_sd[k-1];
		end

		// shift in next dividend bit, subtract when it fits
		assign trial = {cur_rem, cur_low[QW-1]};
		assign ge    = trial >= {1'b0, cur_den};
		assign diff  = trial - {1'b0, cur_den};

		always_ff @(posedge clk) begin
			if (adv) begin
				den_sd[k] <= cur_den;
				rem_sd[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				low_sd[k] <= {cur_low[QW-2:0], 1'b0};
				quo_sd[k] <= {cur_quo[QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctl_sd[k] <= '0;
			else if (adv)
				ctl_sd[k] <= cur_ctl;
		end
	end

	assign quo_ctl = ctl_sd[QW-1];
	assign quo     = quo_sd[QW-1];

endmodule

[rtl/tsm_sqrt.sv]
// Digit-by-digit integer square root, one result bit per stage.
module tsm_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  tsm_pkg::tsm_ctl_t         ctl,
	input  logic [tsm_pkg::QW-1:0]    rad,
	output tsm_pkg::tsm_ctl_t         root_ctl,
	output logic [tsm_pkg::OUT_W-1:0] root
);
	localparam int OW  = tsm_pkg::OUT_W;
	localparam int QW  = tsm_pkg::QW;
	localparam int RMW = tsm_pkg::RMW;

	tsm_pkg::tsm_ctl_t ctl_sr  [OW];
	logic [QW-1:0]     rad_sr  [OW];
	logic [RMW-1:0]    rem_sr  [OW];
	logic [OW-1:0]     root_sr [OW];

	for (genvar k = 0; k < OW; k++) begin : g_step
		tsm_pkg::tsm_ctl_t cur_ctl;
		logic [QW-1:0]     cur_rad;
		logic [RMW-1:0]    cur_rem;
		logic [OW-1:0]     cur_root;
		logic [RMW+1:0]    raw, trial, diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_ctl  = ctl;
			assign cur_rad  = rad;
			assign cur_rem  = '0;
			assign cur_root = '0;
		end else begin : g_next
			assign cur_ctl  = ctl_sr[k-1];
			assign cur_rad  = rad_sr[k-1];
			assign cur_rem  = rem_sr[k-1];
			assign cur_root = root_sr[k-1];
		end

		// bring down two bits, try root*4+1
		assign raw   = {cur_rem, cur_rad[QW-1:QW-2]};
		assign trial = (RMW+2)'({cur_root, 2'b01});
		assign ge    = raw >= trial;
		assign diff  = raw - trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_sr[k]  <= {cur_rad[QW-3:0], 2'b00};
				rem_sr[k]  <= ge ? diff[RMW-1:0] : raw[RMW-1:0];
				root_sr[k] <= {cur_root[OW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctl_sr[k] <= '0;
			else if (adv)
				ctl_sr[k] <= cur_ctl;
		end
	end

	assign root_ctl = ctl_sr[OW-1];
	assign root     = root_sr[OW-1];

endmodule

[rtl/triangle_shape_measure_top.sv]
// Triangle shape measure: circumradius over shortest edge, unsigned Q16.16,
// floor of the exact value, saturated at all ones. One triangle request is
// taken every cycle while ready is high. A result passes 8 front stages,
// one divider stage per quotient bit (64), one root stage per result bit
// (32) and one output register. A two-entry output buffer lets requests
// keep flowing while a result waits; ready drops only when both entries are
// full. A new degenerate threshold (reset 1) goes through thr_q and the
// square registers to the degenerate test. Degenerate triangles give all
// ones with the flag set.
`include "assert_macros.svh"

module triangle_shape_measure_top (
	input  logic         clk,
	input  logic         arst_n,
	tsm_item_if.sink     item,
	tsm_result_if.source result,
	tsm_cfg_if.sink      cfg
);
	localparam int TW = tsm_pkg::TW;
	localparam int HL = tsm_pkg::HL;
	localparam int HH = tsm_pkg::HH;

	logic adv;

	// threshold register
	logic [tsm_pkg::THR_W-1:0] thr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= tsm_pkg::THR_RESET;
		else if (cfg.valid)
			thr_q <= cfg.data;
	end

	// squared threshold, two register steps
	logic [TW-1:0]           thr_fx;
	logic [2*HH-1:0]         t_hh_q;
	logic [HH+HL-1:0]        t_hl_q;
	logic [2*HL-1:0]         t_ll_q;
	logic [tsm_pkg::TSQ_W-1:0] tw_q;

	assign thr_fx = {thr_q, {tsm_pkg::FRAC{1'b0}}};

	always_ff @(posedge clk) begin
		t_hh_q <= (2*HH)'(thr_fx[TW-1:HL] * thr_fx[TW-1:HL]);
		t_hl_q <= (HH+HL)'(thr_fx[TW-1:HL] * thr_fx[HL-1:0]);
		t_ll_q <= (2*HL)'(thr_fx[HL-1:0] * thr_fx[HL-1:0]);
		tw_q   <= (tsm_pkg::TSQ_W'(t_hh_q) << (2*HL))
			+ (tsm_pkg::TSQ_W'(t_hl_q) << (HL+1)) + tsm_pkg::TSQ_W'(t_ll_q);
	end

	// datapath
	tsm_pkg::tsm_coords_t          coords;
	tsm_pkg::tsm_ctl_t             f_ctl, d_ctl, r_ctl;
	logic [tsm_pkg::DW-1:0]        f_den, f_rem;
	logic [tsm_pkg::QW-1:0]        f_low, d_quo;
	logic [tsm_pkg::OUT_W-1:0]     r_root;

	assign coords = {item.p2_z, item.p2_y, item.p2_x, item.p1_z, item.p1_y,
		item.p1_x, item.p0_z, item.p0_y, item.p0_x};

	tsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_valid (item.valid),
		.coords     (coords),
		.tw         (tw_q),
		.ctl        (f_ctl),
		.den        (f_den),
		.rem        (f_rem),
		.low        (f_low)
	);

	tsm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl     (f_ctl),
		.den     (f_den),
		.rem     (f_rem),
		.low     (f_low),
		.quo_ctl (d_ctl),
		.quo     (d_quo)
	);

	tsm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl      (d_ctl),
		.rad      (d_quo),
		.root_ctl (r_ctl),
		.root     (r_root)
	);

	// final select: degenerate or overflow forces all ones
	tsm_pkg::tsm_res_t res_new;

	assign res_new.ratio = (r_ctl.deg || r_ctl.sat) ? '1 : r_root;
	assign res_new.deg   = r_ctl.deg;

	// output register plus skid entry
	logic              o_v_q, s_v_q;
	tsm_pkg::tsm_res_t o_d_q, s_d_q;

	assign adv        = !s_v_q;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			s_v_q <= 1'b0;
		end else if (s_v_q) begin
			if (result.ready)
				s_v_q <= 1'b0;
		end else if (r_ctl.valid) begin
			if (o_v_q && !result.ready)
				s_v_q <= 1'b1;
			else
				o_v_q <= 1'b1;
		end else if (result.ready) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_v_q) begin
			if (result.ready)
				o_d_q <= s_d_q;
		end else if (r_ctl.valid) begin
			if (o_v_q && !result.ready)
				s_d_q <= res_new;
			else
				o_d_q <= res_new;
		end
	end

	assign result.valid       = o_v_q;
	assign result.shape_ratio = o_d_q.ratio;
	assign result.degenerate  = o_d_q.deg;

	`TSM_ASSERT_NOW(a_skid_behind_out, s_v_q, o_v_q)
	`TSM_ASSERT_NOW(a_deg_saturates, o_v_q && o_d_q.deg, o_d_q.ratio == '1)
	`TSM_ASSERT_NEXT(a_out_held, o_v_q && !result.ready, o_v_q)

endmodule
